[design/assert_macros.svh]
// Concurrent assertion helpers, clocked on the rising edge, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[design/segt_pkg.sv]
package segt_pkg;

	localparam int DATA_W     = 32;
	localparam int FIRST_W    = 4;
	localparam int LAST_W     = 5;
	localparam int LEAVES_DEF = 16;

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		data_t sum;
		logic  ok;
	} res_t;

endpackage

[design/segt_ifs.sv]
interface segt_in_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [segt_pkg::FIRST_W-1:0]  first_pos;
	logic [segt_pkg::LAST_W-1:0]   last_pos;
	logic signed [segt_pkg::DATA_W-1:0] value;

	modport source (output valid, op, first_pos, last_pos, value, input ready);
	modport sink   (input valid, op, first_pos, last_pos, value, output ready);
endinterface

interface segt_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [segt_pkg::DATA_W-1:0] sum;
	logic                               ok;

	modport source (output valid, sum, ok, input ready);
	modport sink   (input valid, sum, ok, output ready);
endinterface

[design/segt_mem.sv]
module segt_mem #(
	parameter int DEPTH = 2 * segt_pkg::LEAVES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  segt_pkg::data_t   wdata,
	input  logic [AW-1:0]     ra_addr,
	input  logic [AW-1:0]     rb_addr,
	output segt_pkg::data_t   ra_data,
	output segt_pkg::data_t   rb_data
);
	import segt_pkg::*;

	data_t mem_q [DEPTH];
	data_t ra_q;
	data_t rb_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		ra_q <= mem_q[ra_addr];
		rb_q <= mem_q[rb_addr];
	end

	assign ra_data = ra_q;
	assign rb_data = rb_q;

endmodule

[design/segt_ctrl.sv]
module segt_ctrl #(
	parameter int LEAVES = segt_pkg::LEAVES_DEF,
	parameter int AW     = $clog2(2 * LEAVES)
) (
	input  logic            clk,
	input  logic            arst_n,
	segt_in_if.sink         req,
	output logic            res_valid,
	input  logic            res_ready,
	output segt_pkg::res_t  res,
	output logic            mem_we,
	output logic [AW-1:0]   mem_waddr,
	output segt_pkg::data_t mem_wdata,
	output logic [AW-1:0]   mem_ra,
	output logic [AW-1:0]   mem_rb,
	input  segt_pkg::data_t mem_rda,
	input  segt_pkg::data_t mem_rdb
);
	import segt_pkg::*;

	localparam int LW = $clog2(2 * LEAVES + 1);
	localparam int CW = (LW > LAST_W) ? LW : LAST_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_UP_WR,
		S_UP_ADD,
		S_Q_RD,
		S_Q_ACC,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   k_q;
	data_t           cur_q;
	logic [LW-1:0]   l_q;
	logic [LW-1:0]   r_q;
	logic            take_l_q;
	logic            take_r_q;
	data_t           acc_q;
	res_t            res_q;

	logic [CW-1:0]   first_c;
	logic [CW-1:0]   lo_c;
	logic [CW-1:0]   hi_c;
	logic [LW-1:0]   r_dec;
	data_t           add_a;
	data_t           add_b;

	always_comb begin
		first_c = CW'(req.first_pos);
		lo_c    = (first_c > CW'(LEAVES)) ? CW'(LEAVES) : first_c;
		hi_c    = (CW'(req.last_pos) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(req.last_pos);
		r_dec   = r_q - LW'(1);
		add_a   = take_l_q ? mem_rda : '0;
		add_b   = take_r_q ? mem_rdb : '0;
	end

	// memory port drive
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = k_q;
		mem_wdata = cur_q;
		mem_ra    = k_q ^ AW'(1);
		mem_rb    = r_dec[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_UP_WR: begin
				mem_we = 1'b1;
			end
			S_Q_RD: begin
				mem_ra = l_q[AW-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			k_q      <= '0;
			cur_q    <= '0;
			l_q      <= '0;
			r_q      <= '0;
			take_l_q <= 1'b0;
			take_r_q <= 1'b0;
			acc_q    <= '0;
			res_q    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(2 * LEAVES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						if (req.op == OP_SET) begin
							if (first_c < CW'(LEAVES)) begin
								k_q     <= AW'(first_c + CW'(LEAVES));
								cur_q   <= req.value;
								state_q <= S_UP_WR;
							end else begin
								res_q   <= '{sum: '0, ok: 1'b0};
								state_q <= S_DONE;
							end
						end else if (lo_c < hi_c) begin
							l_q     <= LW'(lo_c + CW'(LEAVES));
							r_q     <= LW'(hi_c + CW'(LEAVES));
							acc_q   <= '0;
							state_q <= S_Q_RD;
						end else begin
							res_q   <= '{sum: '0, ok: 1'b0};
							state_q <= S_DONE;
						end
					end
				end
				S_UP_WR: begin
					if (k_q == AW'(1)) begin
						res_q   <= '{sum: '0, ok: 1'b1};
						state_q <= S_DONE;
					end else begin
						state_q <= S_UP_ADD;
					end
				end
				S_UP_ADD: begin
					cur_q   <= cur_q + mem_rda;
					k_q     <= k_q >> 1;
					state_q <= S_UP_WR;
				end
				S_Q_RD: begin
					if (l_q < r_q) begin
						take_l_q <= l_q[0];
						take_r_q <= r_q[0];
						l_q      <= (l_q + LW'(l_q[0])) >> 1;
						r_q      <= r_q >> 1;
						state_q  <= S_Q_ACC;
					end else begin
						res_q   <= '{sum: acc_q, ok: 1'b1};
						state_q <= S_DONE;
					end
				end
				S_Q_ACC: begin
					acc_q   <= acc_q + add_a + add_b;
					state_q <= S_Q_RD;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[design/segment_tree_range_sum_top.sv]
// Walks: from acceptance, a set goes from its leaf up to the root and a query bottom-up
// until its bounds meet, then the result moves to the output register; each tree level
// takes a read state and an add state, as the node memory has one write port and registered read ports.
// Flow: one item in flight; ready rises again in the cycle after the result leaves the controller,
// and the result waits there while the output register is full and the consumer is not ready.
// Reset: asynchronous, active low; ready stays low while the clearing pass zeroes the node memory.
`include "assert_macros.svh"

module segment_tree_range_sum_top #(
	parameter int LEAVES = segt_pkg::LEAVES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	segt_in_if.sink   req,
	segt_out_if.source rsp
);
	import segt_pkg::*;

	// Heap order with node k at address k; address 0 is never used.
	localparam int DEPTH = 2 * LEAVES;
	localparam int AW    = $clog2(DEPTH);

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	data_t         mem_wdata;
	logic [AW-1:0] mem_ra;
	logic [AW-1:0] mem_rb;
	data_t         mem_rda;
	data_t         mem_rdb;

	logic          out_vld_q;
	res_t          out_q;

	// Sequencer: clearing pass, leaf-to-root update walk, bottom-up range walk.
	segt_ctrl #(
		.LEAVES (LEAVES),
		.AW     (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_ra    (mem_ra),
		.mem_rb    (mem_rb),
		.mem_rda   (mem_rda),
		.mem_rdb   (mem_rdb)
	);

	// Node sums: one write port, two registered read ports (left and right range edge).
	segt_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.ra_addr (mem_ra),
		.rb_addr (mem_rb),
		.ra_data (mem_rda),
		.rb_data (mem_rdb)
	);

	// Output register: hold the finished result here so the controller can free up and
	// take the next transaction while the consumer stalls.
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.sum   = out_q.sum;
	assign rsp.ok    = out_q.ok;

	// Only one transaction is worked on at a time.
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, req.valid && req.ready, !req.ready, "second item taken while busy")
	// A rejected item never carries a sum.
	`ASSERT_NOW(a_reject_zero, clk, arst_n, res_valid && !res.ok, res.sum == '0, "nonzero sum with ok low")
	// A finished result stays offered while the output register is blocked.
	`ASSERT_NEXT(a_res_held, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res), "result dropped under stall")

endmodule
